// ===== rtl/core/ccf_pkg.sv =====
// Shared types and constants of the copier command framer.
// Used by ccf_front, ccf_queue, ccf_back, copier_command_framer and tb; no dependencies.
`timescale 1ns / 1ps

package ccf_pkg;

    // Depth of the job queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_OUT   = 2'd1;
    localparam logic [1:0] OP_IN    = 2'd2;

    // Command codes that carry a data phase
    localparam logic [7:0] CMD_MEM_UP     = 8'h00;
    localparam logic [7:0] CMD_MEM_DOWN   = 8'h01;
    localparam logic [7:0] CMD_VIDEO_UP   = 8'h02;
    localparam logic [7:0] CMD_VIDEO_DOWN = 8'h03;

    // Line constants
    localparam logic [7:0] SYNC_0     = 8'hD5;
    localparam logic [7:0] SYNC_1     = 8'hAA;
    localparam logic [7:0] SYNC_2     = 8'h96;
    localparam logic [7:0] CHECK_SEED = 8'h81;

    // Result status codes
    localparam logic [2:0] ST_SENT     = 3'd0;
    localparam logic [2:0] ST_RECV     = 3'd1;
    localparam logic [2:0] ST_MATCH    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_PHASE    = 3'd4;

    // Byte positions inside a job
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] FB_SYNC_0 = 4'd0;
    localparam logic [IDX_W-1:0] FB_SYNC_1 = 4'd1;
    localparam logic [IDX_W-1:0] FB_SYNC_2 = 4'd2;
    localparam logic [IDX_W-1:0] FB_CMD    = 4'd3;
    localparam logic [IDX_W-1:0] FB_ADDR_L = 4'd4;
    localparam logic [IDX_W-1:0] FB_ADDR_H = 4'd5;
    localparam logic [IDX_W-1:0] FB_LEN_L  = 4'd6;
    localparam logic [IDX_W-1:0] FB_LEN_H  = 4'd7;
    localparam logic [IDX_W-1:0] FB_CHK    = 4'd8;
    localparam logic [IDX_W-1:0] FB_SEED   = 4'd9;

    // Link phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_UPLOAD   = 4'b0010,
        PH_DOWNLOAD = 4'b0100,
        PH_CHECK    = 4'b1000
    } t_phase;

    // Kind of job handed to the back
    typedef enum logic [2:0] {
        JK_SINGLE = 3'b001,   // one byte
        JK_PAIR   = 3'b010,   // data byte, then upload checksum
        JK_FRAME  = 3'b100    // nine-byte command frame, maybe plus seed byte
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  cmd;
        logic [15:0] addr;
        logic [15:0] len;
        logic [7:0]  chk;
        logic        extra;      // append the seed byte after the frame
        logic [7:0]  byte_a;
        logic [2:0]  status_a;
        logic [7:0]  byte_b;
    } t_job;

endpackage

// ===== rtl/core/copier_command_framer.sv =====
// Top level of the copier command framer: front, job queue and back.
// Depends on ccf_pkg, ccf_front, ccf_queue and ccf_back.
`timescale 1ns / 1ps

// Usage
//   Slave channel: one transaction per item. tuser carries the operation
//   (send a command frame, outbound data byte, inbound byte from the device);
//   tdata carries command, address, length and data.
//   Master channel: one transaction per line byte. tdata carries the byte and
//   its status, tlast marks the final result caused by one input item.
//   A command frame yields nine bytes (ten for an upload of length zero),
//   a data byte one, and the final upload data byte two.
// Path: the first result of an item passes through the job queue and then
//   the output register before it is offered.
// Throughput: the front takes one item per cycle while the job queue
//   (QUEUE_DEPTH entries) has room. The back emits one byte per cycle while
//   the receiver takes them; while it works through a frame the queue
//   absorbs the items that follow.
// Reset: synchronous, active low; the link phase returns to idle, the data
//   checksum to its seed and the queue and output register empty.
// Stall: when the receiver drops tready the output register holds its byte,
//   the back stops, the queue fills and then tready on the slave side drops.
module copier_command_framer
    import ccf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // command[7:0], address[23:8], length[39:24], data[47:40]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_byte[7:0], status[10:8], zero[15:11]
    output logic        o_m_tlast
);

    logic       w_push, w_full, w_pop, w_q_valid;
    t_job       w_job_in, w_job_head;
    logic [7:0] w_byte;
    logic [2:0] w_status;

    // Classify each transaction and advance the link phase
    ccf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_operation (i_s_tuser),
        .i_command   (i_s_tdata[7:0]),
        .i_address   (i_s_tdata[23:8]),
        .i_length    (i_s_tdata[39:24]),
        .i_data      (i_s_tdata[47:40]),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    // Decouple classification from byte output
    ccf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_job_head)
    );

    // Expand jobs into line bytes, one per cycle while the receiver takes them
    ccf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_job_head),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (w_byte),
        .o_status  (w_status),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {5'b00000, w_status, w_byte};

endmodule

// ===== rtl/core/ccf_front.sv =====
// Front of the copier command framer: classifies each item and tracks the link phase.
// Depends on ccf_pkg.
`timescale 1ns / 1ps

module ccf_front
    import ccf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_left,  n_left;
    logic [7:0]  r_check, n_check;

    logic [7:0]  w_frame_chk;
    logic [7:0]  w_check_xor;
    logic [15:0] w_left_m1;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign w_frame_chk = CHECK_SEED ^ i_command ^ i_address[7:0] ^ i_address[15:8]
                         ^ i_length[7:0] ^ i_length[15:8];
    assign w_check_xor = r_check ^ i_data;
    assign w_left_m1   = r_left - 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_check = r_check;

        o_job.kind     = JK_SINGLE;
        o_job.cmd      = i_command;
        o_job.addr     = i_address;
        o_job.len      = i_length;
        o_job.chk      = w_frame_chk;
        o_job.extra    = 1'b0;
        o_job.byte_a   = 8'h00;
        o_job.status_a = ST_PHASE;
        o_job.byte_b   = w_check_xor;

        if (i_operation == OP_FRAME && r_phase == PH_IDLE) begin
            o_job.kind = JK_FRAME;
            n_check    = CHECK_SEED;
            n_left     = i_length;
            if (i_command inside {CMD_MEM_UP, CMD_VIDEO_UP}) begin
                if (i_length == 16'd0) begin
                    o_job.extra = 1'b1;
                end else begin
                    n_phase = PH_UPLOAD;
                end
            end else if (i_command inside {CMD_MEM_DOWN, CMD_VIDEO_DOWN}) begin
                n_phase = (i_length == 16'd0) ? PH_CHECK : PH_DOWNLOAD;
            end else begin
                n_left = 16'd0;
            end
        end else if (i_operation == OP_OUT && r_phase == PH_UPLOAD) begin
            o_job.byte_a   = i_data;
            o_job.status_a = ST_SENT;
            n_check        = w_check_xor;
            n_left         = w_left_m1;
            if (w_left_m1 == 16'd0) begin
                // last data byte: append the running checksum
                o_job.kind = JK_PAIR;
                n_phase    = PH_IDLE;
                n_check    = CHECK_SEED;
            end
        end else if (i_operation == OP_IN && r_phase == PH_DOWNLOAD) begin
            o_job.byte_a   = i_data;
            o_job.status_a = ST_RECV;
            n_check        = w_check_xor;
            n_left         = w_left_m1;
            if (w_left_m1 == 16'd0) begin
                n_phase = PH_CHECK;
            end
        end else if (i_operation == OP_IN && r_phase == PH_CHECK) begin
            o_job.byte_a   = i_data;
            o_job.status_a = (i_data == r_check) ? ST_MATCH : ST_MISMATCH;
            n_phase        = PH_IDLE;
            n_left         = 16'd0;
            n_check        = CHECK_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= 16'd0;
            r_check <= CHECK_SEED;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_check <= n_check;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_left == 16'd0 && r_check == CHECK_SEED))
        else $error("idle phase with pending count or checksum");

    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UPLOAD || r_phase == PH_DOWNLOAD) |-> r_left != 16'd0)
        else $error("data phase with no bytes left");

endmodule

// ===== rtl/core/ccf_queue.sv =====
// Job queue between the front and the back of the copier command framer.
// Depends on ccf_pkg.
`timescale 1ns / 1ps

module ccf_queue
    import ccf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("job queue overflow or underflow");

endmodule

// ===== rtl/core/ccf_back.sv =====
// Back of the copier command framer: expands queued jobs into line bytes.
// Depends on ccf_pkg.
`timescale 1ns / 1ps

module ccf_back
    import ccf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic [2:0]       r_status;
    logic             r_last;

    logic [7:0] w_byte;
    logic [2:0] w_status;
    logic       w_final;
    logic       w_load;

    always_comb begin
        w_byte   = i_job.byte_a;
        w_status = ST_SENT;
        w_final  = 1'b1;
        case (i_job.kind)
            JK_SINGLE: begin
                w_status = i_job.status_a;
            end
            JK_PAIR: begin
                w_final = (r_idx != '0);
                w_byte  = (r_idx == '0) ? i_job.byte_a : i_job.byte_b;
            end
            JK_FRAME: begin
                w_final = i_job.extra ? (r_idx == FB_SEED) : (r_idx == FB_CHK);
                case (r_idx)
                    FB_SYNC_0: w_byte = SYNC_0;
                    FB_SYNC_1: w_byte = SYNC_1;
                    FB_SYNC_2: w_byte = SYNC_2;
                    FB_CMD:    w_byte = i_job.cmd;
                    FB_ADDR_L: w_byte = i_job.addr[7:0];
                    FB_ADDR_H: w_byte = i_job.addr[15:8];
                    FB_LEN_L:  w_byte = i_job.len[7:0];
                    FB_LEN_H:  w_byte = i_job.len[15:8];
                    FB_CHK:    w_byte = i_job.chk;
                    default:   w_byte = CHECK_SEED;
                endcase
            end
            default: begin
                w_status = i_job.status_a;
            end
        endcase
    end

    assign w_load = i_q_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= w_byte;
            r_status <= w_status;
            r_last   <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? '0 : r_idx + 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_status = r_status;
    assign o_last   = r_last;

    a_mid_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> i_q_valid)
        else $error("job left the queue before its last byte");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for copier_command_framer: stream driver, result monitor, predictor.
// Depends on ccf_pkg and the copier_command_framer RTL; reads no files.
`timescale 1ns / 1ps

module tb;
    import ccf_pkg::*;

    // Operation code that the block must always flag as out of phase
    localparam logic [1:0] OP_BAD = 2'd3;
    // Generous limit: all items, up to ten bytes each, each byte stalled by a drawn wait,
    // plus sender gaps and the long receiver hold-off, taken several times
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int TOTAL_ITEMS = 100;

    // One input item: operation in tuser, the rest packed into tdata
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd;
        logic [15:0] addr;
        logic [15:0] len;
        logic [7:0]  data;
    } t_copier_item;

    // One line byte as the block should emit it
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_line_byte;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;     // command[7:0], address[23:8], length[39:24], data[47:40]
    logic [1:0]  i_s_tuser = '0;     // operation[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;          // out_byte[7:0], status[10:8], zero[15:11]
    logic        o_m_tlast;

    copier_command_framer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Items waiting for the driver, and line bytes still owed by the block
    t_copier_item pending_items[$];
    t_line_byte   owed_bytes[$];

    // Predictor state: link phase, data bytes still due, running data checksum
    t_phase       link_phase = PH_IDLE;
    logic [15:0]  bytes_due = '0;
    logic [7:0]   data_check = CHECK_SEED;

    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;
    int unsigned  n_queued = 0;
    int unsigned  n_offered = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_results = 0;
    int unsigned  hold_req = 0;
    int unsigned  hold_seen = 0;

    // Driver and receiver bookkeeping
    t_copier_item offer = '0;
    logic         offering = 1'b0;
    int           src_gap = 0;
    int           src_run = 0;
    int           rx_gap = 0;
    int           rx_run = 0;
    int           hold_left = 0;
    int unsigned  rx_seen = 0;
    logic         rx_ready;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Draw a random wait; now and then start a run of back-to-back items
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left = run_left - 1;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic owe_byte(input logic [7:0] b, input logic [2:0] st, input logic last);
        t_line_byte lb;
        lb.out_byte = b;
        lb.status   = st;
        lb.last     = last;
        owed_bytes.push_back(lb);
    endtask

    // Work out the line bytes one accepted item causes and advance the link state
    task automatic predict_line(input t_copier_item it);
        logic [7:0] chk;
        logic       is_up;
        logic       is_down;
        is_up   = (it.cmd == CMD_MEM_UP) || (it.cmd == CMD_VIDEO_UP);
        is_down = (it.cmd == CMD_MEM_DOWN) || (it.cmd == CMD_VIDEO_DOWN);
        if (it.op == OP_FRAME && link_phase == PH_IDLE) begin
            chk = CHECK_SEED ^ it.cmd ^ it.addr[7:0] ^ it.addr[15:8]
                  ^ it.len[7:0] ^ it.len[15:8];
            owe_byte(SYNC_0, ST_SENT, 1'b0);
            owe_byte(SYNC_1, ST_SENT, 1'b0);
            owe_byte(SYNC_2, ST_SENT, 1'b0);
            owe_byte(it.cmd, ST_SENT, 1'b0);
            owe_byte(it.addr[7:0], ST_SENT, 1'b0);
            owe_byte(it.addr[15:8], ST_SENT, 1'b0);
            owe_byte(it.len[7:0], ST_SENT, 1'b0);
            owe_byte(it.len[15:8], ST_SENT, 1'b0);
            // an empty upload closes with the bare seed right after the frame
            owe_byte(chk, ST_SENT, !(is_up && it.len == 16'd0));
            data_check = CHECK_SEED;
            bytes_due  = it.len;
            if (is_up) begin
                if (it.len == 16'd0) begin
                    owe_byte(CHECK_SEED, ST_SENT, 1'b1);
                end else begin
                    link_phase = PH_UPLOAD;
                end
            end else if (is_down) begin
                if (it.len == 16'd0) begin
                    link_phase = PH_CHECK;
                end else begin
                    link_phase = PH_DOWNLOAD;
                end
            end else begin
                bytes_due = '0;
            end
        end else if (it.op == OP_OUT && link_phase == PH_UPLOAD) begin
            data_check = data_check ^ it.data;
            bytes_due  = bytes_due - 16'd1;
            owe_byte(it.data, ST_SENT, bytes_due != 16'd0);
            if (bytes_due == 16'd0) begin
                owe_byte(data_check, ST_SENT, 1'b1);
                link_phase = PH_IDLE;
                data_check = CHECK_SEED;
            end
        end else if (it.op == OP_IN && link_phase == PH_DOWNLOAD) begin
            owe_byte(it.data, ST_RECV, 1'b1);
            data_check = data_check ^ it.data;
            bytes_due  = bytes_due - 16'd1;
            if (bytes_due == 16'd0) begin
                link_phase = PH_CHECK;
            end
        end else if (it.op == OP_IN && link_phase == PH_CHECK) begin
            owe_byte(it.data, (it.data == data_check) ? ST_MATCH : ST_MISMATCH, 1'b1);
            link_phase = PH_IDLE;
            bytes_due  = '0;
            data_check = CHECK_SEED;
        end else begin
            // out of phase: one flagged byte, state untouched
            owe_byte(8'h00, ST_PHASE, 1'b1);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (mismatches < 10) begin
            $display("tb: result %0d %s expected %h actual %h", n_results, what, want, got);
        end
        mismatches = mismatches + 1;
    endtask

    // Driver: change slave inputs at the falling edge; advance to the next item
    // once the previous transaction has been taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (offering && n_accepted == n_offered) begin
                offering = 1'b0;
                src_gap  = draw_wait(src_run);
            end
            if (!offering) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                end else if (pending_items.size() != 0) begin
                    offer     = pending_items.pop_front();
                    offering  = 1'b1;
                    n_offered = n_offered + 1;
                end
            end
        end
        i_s_tvalid <= offering;
        i_s_tdata  <= {offer.data, offer.len, offer.addr, offer.cmd};
        i_s_tuser  <= offer.op;
    end

    // Receiver: stall for a drawn number of cycles after each result; on request
    // hold off for a long stretch so the job queue fills and the input stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_seen != n_results) begin
                rx_seen = n_results;
                rx_gap  = draw_wait(rx_run);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                rx_ready  = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   = rx_gap - 1;
                rx_ready = 1'b0;
            end else begin
                rx_ready = 1'b1;
            end
        end else begin
            rx_ready = 1'b0;
        end
        i_m_tready <= rx_ready;
    end

    // Monitor: at the rising edge check each result transaction against the
    // oldest owed byte, and predict the bytes of each accepted item
    always @(posedge i_clk) begin
        t_line_byte want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (owed_bytes.size() == 0) begin
                    note_mismatch("unexpected byte", 8'h00, o_m_tdata[7:0]);
                end else begin
                    want = owed_bytes.pop_front();
                    if (o_m_tdata[7:0] !== want.out_byte)
                        note_mismatch("out_byte", want.out_byte, o_m_tdata[7:0]);
                    if (o_m_tdata[10:8] !== want.status)
                        note_mismatch("status", {5'd0, want.status}, {5'd0, o_m_tdata[10:8]});
                    if (o_m_tlast !== want.last)
                        note_mismatch("tlast", {7'd0, want.last}, {7'd0, o_m_tlast});
                end
                n_results = n_results + 1;
            end
            if (i_s_tvalid && o_s_tready) begin
                n_accepted = n_accepted + 1;
                predict_line(offer);
            end
        end
    end

    // Watchdog: end the run if it never drains
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("copier_command_framer: mismatch");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [7:0] cmd,
                            input logic [15:0] addr, input logic [15:0] len,
                            input logic [7:0] data);
        t_copier_item it;
        it.op   = op;
        it.cmd  = cmd;
        it.addr = addr;
        it.len  = len;
        it.data = data;
        pending_items.push_back(it);
        n_queued = n_queued + 1;
    endtask

    // Queue one item that the current phase must reject; idle strays are data
    // or bad operations, never frames, so the link never gets stuck
    task automatic add_stray(input t_phase ph);
        int pick;
        pick = $urandom_range(0, 2);
        if (ph == PH_IDLE) begin
            case (pick)
                0: add_item(OP_OUT, rnd8(), rnd16(), rnd16(), rnd8());
                1: add_item(OP_IN, rnd8(), rnd16(), rnd16(), rnd8());
                default: add_item(OP_BAD, rnd8(), rnd16(), rnd16(), rnd8());
            endcase
        end else begin
            case (pick)
                0: add_item(OP_FRAME, rnd8(), rnd16(), rnd16(), rnd8());
                1: add_item((ph == PH_UPLOAD) ? OP_IN : OP_OUT,
                            rnd8(), rnd16(), rnd16(), rnd8());
                default: add_item(OP_BAD, rnd8(), rnd16(), rnd16(), rnd8());
            endcase
        end
    endtask

    // Hold the sender until every owed byte has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || n_accepted != n_offered
               || owed_bytes.size() != 0 || hold_seen != hold_req || hold_left != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          i;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  d;
        logic [7:0]  sum;
        logic        up;
        logic        down;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stray items while idle, operation 3 with every bit set
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'h55);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'hAA);
        add_item(OP_BAD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        // frames without a data phase at both field extremes
        add_item(OP_FRAME, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_item(OP_FRAME, 8'h5A, 16'h0000, 16'h0000, 8'h00);
        // empty upload: frame plus seed byte
        add_item(OP_FRAME, CMD_MEM_UP, 16'hBEEF, 16'h0000, 8'h00);
        // video upload of three bytes with strays mixed in
        add_item(OP_FRAME, CMD_VIDEO_UP, 16'h1234, 16'h0003, 8'h00);
        add_item(OP_FRAME, CMD_MEM_UP, 16'h0000, 16'h0000, 8'h00);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'h11);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'h00);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'hFF);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'hA5);
        // download of two bytes with a matching checksum
        add_item(OP_FRAME, CMD_MEM_DOWN, 16'h8000, 16'h0002, 8'h00);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'h22);
        add_item(OP_FRAME, CMD_MEM_DOWN, 16'h0000, 16'h0001, 8'h00);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'h3C);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'hC3);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, CHECK_SEED ^ 8'h3C ^ 8'hC3);
        // empty video download goes straight to the checksum; send a wrong one
        add_item(OP_FRAME, CMD_VIDEO_DOWN, 16'h00FF, 16'h0000, 8'h00);
        add_item(OP_OUT, 8'h00, 16'h0000, 16'h0000, 8'h33);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'h00);
        // one-byte download whose checksum comes out zero
        add_item(OP_FRAME, CMD_MEM_DOWN, 16'h4321, 16'h0001, 8'h00);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, CHECK_SEED);
        add_item(OP_IN, 8'h00, 16'h0000, 16'h0000, 8'h00);

        // Pause the sender until the block has emptied
        wait_drained();

        // Random: mostly complete transfers with random content, some with
        // stray items inside, plus stray items between transfers
        while (n_queued < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                cmd = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 5) == 0)
                    cmd = 8'($urandom_range(4, 255));
                if ($urandom_range(0, 9) == 0)
                    len = 16'($urandom_range(9, 40));
                else
                    len = 16'($urandom_range(0, 8));
                up   = (cmd == CMD_MEM_UP) || (cmd == CMD_VIDEO_UP);
                down = (cmd == CMD_MEM_DOWN) || (cmd == CMD_VIDEO_DOWN);
                add_item(OP_FRAME, cmd, rnd16(), len, rnd8());
                sum = CHECK_SEED;
                if (up || down) begin
                    for (i = 0; i < len; i++) begin
                        if ($urandom_range(0, 11) == 0)
                            add_stray(up ? PH_UPLOAD : PH_DOWNLOAD);
                        d   = rnd8();
                        sum = sum ^ d;
                        add_item(up ? OP_OUT : OP_IN, rnd8(), rnd16(), rnd16(), d);
                    end
                end
                if (down) begin
                    if ($urandom_range(0, 7) == 0)
                        add_stray(PH_CHECK);
                    if ($urandom_range(0, 1) == 0)
                        d = sum;
                    else
                        d = rnd8();
                    add_item(OP_IN, rnd8(), rnd16(), rnd16(), d);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                // frame with no data phase and fully random address and length
                add_item(OP_FRAME, 8'($urandom_range(4, 255)), rnd16(), rnd16(), rnd8());
            end else begin
                add_stray(PH_IDLE);
            end
        end

        // Hold off the receiver while the sender keeps offering
        hold_req = hold_req + 1;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && owed_bytes.size() == 0) begin
            $display("copier_command_framer: match");
        end else begin
            $display("copier_command_framer: mismatch");
        end
        $finish;
    end

endmodule
